@@ rtl/bsp_pkg.sv @@
// Shared opcodes, status codes and field widths for the binary search probe controller.
`default_nettype none

package bsp_pkg;

    localparam int OP_W = 3;
    localparam int ST_W = 2;

    localparam logic [OP_W-1:0] OP_START = 3'd0;
    localparam logic [OP_W-1:0] OP_EQUAL = 3'd1;
    localparam logic [OP_W-1:0] OP_LEFT  = 3'd2;
    localparam logic [OP_W-1:0] OP_RIGHT = 3'd3;
    localparam logic [OP_W-1:0] OP_SKIP  = 3'd4;

    localparam logic [ST_W-1:0] ST_CONTINUE  = 2'd0;
    localparam logic [ST_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

endpackage

`default_nettype wire

@@ rtl/binary_search_probe_controller.sv @@
// Top level of the binary search probe controller: input stage, search state and result register.
//
//  channel | dir | tdata (low bit up)                         | tuser (low bit up)
//  s_axis  | in  | start_index, stop_index                    | opcode
//  m_axis  | out | check_index, found_index, zero pad         | search_status, start_rejected
//
// One command per cycle sustained while the output is not stalled; a command is held
// in the input register, then its result and the new search state are written
// together by the step logic.
// rst_n clears the search state to finished-not-found and empties both stages.
// A stalled output holds its result; the input register still takes one transaction.
`default_nettype none

module binary_search_probe_controller #(
    parameter int INDEX_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // start_index, stop_index, zero pad
    input  wire logic [((2*INDEX_BITS+7)/8)*8-1:0]   s_tdata,
    // opcode
    input  wire logic [bsp_pkg::OP_W-1:0]            s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // check_index, found_index, zero pad
    output logic      [((2*INDEX_BITS+10)/8)*8-1:0]  m_tdata,
    // search_status, start_rejected
    output logic      [bsp_pkg::ST_W:0]              m_tuser
);
    import bsp_pkg::*;

    localparam int OW         = INDEX_BITS + 2;
    localparam int FW         = INDEX_BITS + 1;
    localparam int OUT_DATA_W = ((2*INDEX_BITS+10)/8)*8;
    localparam int PAD_W      = OUT_DATA_W - OW - FW;

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [OP_W-1:0]       op_reg;
    logic [INDEX_BITS-1:0] start_reg;
    logic [INDEX_BITS-1:0] stop_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OW-1:0]         check_reg;
    logic [FW-1:0]         found_reg;
    logic [ST_W-1:0]       status_out_reg;
    logic                  rejected_reg;

    logic [INDEX_BITS-1:0] left_reg;
    logic [INDEX_BITS-1:0] right_reg;
    logic [INDEX_BITS-1:0] pivot_reg;
    logic [OW-1:0]         offset_reg;
    logic [ST_W-1:0]       status_reg;

    logic [INDEX_BITS-1:0] left_next;
    logic [INDEX_BITS-1:0] right_next;
    logic [INDEX_BITS-1:0] pivot_next;
    logic [OW-1:0]         offset_next;
    logic [ST_W-1:0]       status_next;
    logic [OW-1:0]         check_next;
    logic [FW-1:0]         found_next;
    logic                  rejected_next;

    logic advance;
    logic in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    bsp_step #(
        .INDEX_BITS(INDEX_BITS)
    ) u_step (
        .opcode            (op_reg),
        .start_index       (start_reg),
        .stop_index        (stop_reg),
        .left_bound        (left_reg),
        .right_bound       (right_reg),
        .pivot             (pivot_reg),
        .probe_offset      (offset_reg),
        .status            (status_reg),
        .left_bound_next   (left_next),
        .right_bound_next  (right_next),
        .pivot_next        (pivot_next),
        .probe_offset_next (offset_next),
        .status_next       (status_next),
        .check_index       (check_next),
        .found_index       (found_next),
        .start_rejected    (rejected_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            right_reg     <= '0;
            pivot_reg     <= '0;
            offset_reg    <= '0;
            status_reg    <= ST_NOT_FOUND;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                left_reg   <= left_next;
                right_reg  <= right_next;
                pivot_reg  <= pivot_next;
                offset_reg <= offset_next;
                status_reg <= status_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg    <= s_tuser;
            start_reg <= s_tdata[INDEX_BITS-1:0];
            stop_reg  <= s_tdata[2*INDEX_BITS-1:INDEX_BITS];
        end
        if (advance)
        begin
            check_reg      <= check_next;
            found_reg      <= found_next;
            status_out_reg <= status_next;
            rejected_reg   <= rejected_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, found_reg, check_reg};
    assign m_tuser  = {rejected_reg, status_out_reg};

`ifndef NO_ASSERTIONS
    a_found_only_when_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status_out_reg != ST_FOUND) |-> (found_reg == '1))
        else $error("found index set without found status");

    a_found_matches_check: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status_out_reg == ST_FOUND) |-> (found_reg == check_reg[FW-1:0]))
        else $error("found index differs from check index");

    a_finished_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && op_reg != OP_START && status_reg != ST_CONTINUE)
            |=> $stable(status_reg) && $stable(offset_reg) && $stable(pivot_reg))
        else $error("finished search changed by an outcome command");

    a_reject_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && rejected_next) |=> $stable(status_reg) && $stable(left_reg)
            && $stable(right_reg))
        else $error("rejected start changed the search state");
`endif

endmodule

`default_nettype wire

@@ rtl/bsp_step.sv @@
// Next-state and result logic for one command of the binary search probe controller.
`default_nettype none

module bsp_step #(
    parameter int INDEX_BITS = 16
) (
    input  wire logic [bsp_pkg::OP_W-1:0]  opcode,
    input  wire logic [INDEX_BITS-1:0]     start_index,
    input  wire logic [INDEX_BITS-1:0]     stop_index,
    input  wire logic [INDEX_BITS-1:0]     left_bound,
    input  wire logic [INDEX_BITS-1:0]     right_bound,
    input  wire logic [INDEX_BITS-1:0]     pivot,
    input  wire logic [INDEX_BITS+1:0]     probe_offset,
    input  wire logic [bsp_pkg::ST_W-1:0]  status,
    output logic      [INDEX_BITS-1:0]     left_bound_next,
    output logic      [INDEX_BITS-1:0]     right_bound_next,
    output logic      [INDEX_BITS-1:0]     pivot_next,
    output logic      [INDEX_BITS+1:0]     probe_offset_next,
    output logic      [bsp_pkg::ST_W-1:0]  status_next,
    output logic      [INDEX_BITS+1:0]     check_index,
    output logic      [INDEX_BITS:0]       found_index,
    output logic                           start_rejected
);
    import bsp_pkg::*;

    localparam int OW = INDEX_BITS + 2;
    localparam int NW = INDEX_BITS + 3;
    localparam logic signed [NW-1:0] ONE_N = NW'(1);

    // zig-zag: 0 -> +1, +k -> -k, -k -> +k+1
    function automatic logic [OW-1:0] next_offset(input logic [OW-1:0] off);
        logic [OW-1:0] res;
        if (off == '0)
            res = OW'(1);
        else if (!off[OW-1])
            res = -off;
        else
            res = -off + OW'(1);
        return res;
    endfunction

    function automatic logic [INDEX_BITS-1:0] mid(input logic [INDEX_BITS-1:0] lo,
                                                  input logic [INDEX_BITS-1:0] hi);
        logic [INDEX_BITS:0] sum;
        sum = {1'b0, lo} + {1'b0, hi};
        return sum[INDEX_BITS:1];
    endfunction

    logic signed [NW-1:0] piv_x;
    logic signed [NW-1:0] left_x;
    logic signed [NW-1:0] right_x;
    logic signed [NW-1:0] off_x;
    logic signed [NW-1:0] skip_x;
    logic signed [NW-1:0] nb_left;
    logic signed [NW-1:0] nb_right;
    logic signed [NW-1:0] nb_skip;
    logic signed [NW-1:0] chk_x;
    logic [OW-1:0]        off_skip;
    logic                 off_pos;
    logic                 off_neg;

    assign piv_x    = $signed({3'b000, pivot});
    assign left_x   = $signed({3'b000, left_bound});
    assign right_x  = $signed({3'b000, right_bound});
    assign off_x    = $signed({probe_offset[OW-1], probe_offset});
    assign off_neg  = probe_offset[OW-1];
    assign off_pos  = !off_neg && (probe_offset != '0);
    assign off_skip = next_offset(probe_offset);
    assign skip_x   = $signed({off_skip[OW-1], off_skip});

    assign nb_left  = off_pos ? (piv_x - off_x) : (piv_x + off_x - ONE_N);
    assign nb_right = off_neg ? (piv_x - off_x + ONE_N) : (piv_x + off_x + ONE_N);
    assign nb_skip  = piv_x + skip_x;

    always_comb
    begin
        left_bound_next   = left_bound;
        right_bound_next  = right_bound;
        pivot_next        = pivot;
        probe_offset_next = probe_offset;
        status_next       = status;
        start_rejected    = 1'b0;
        if (opcode == OP_START)
        begin
            if (start_index >= stop_index)
            begin
                start_rejected = 1'b1;
            end
            else
            begin
                status_next       = ST_CONTINUE;
                left_bound_next   = start_index;
                right_bound_next  = stop_index;
                pivot_next        = mid(start_index, stop_index);
                probe_offset_next = '0;
            end
        end
        else if (status == ST_CONTINUE)
        begin
            unique case (opcode)
                OP_EQUAL:
                begin
                    status_next = ST_FOUND;
                end
                OP_LEFT:
                begin
                    if (nb_left >= right_x || nb_left < left_x)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        right_bound_next  = nb_left[INDEX_BITS-1:0];
                        pivot_next        = mid(left_bound, nb_left[INDEX_BITS-1:0]);
                        probe_offset_next = '0;
                    end
                end
                OP_RIGHT:
                begin
                    if (nb_right <= left_x || nb_right > right_x)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        left_bound_next   = nb_right[INDEX_BITS-1:0];
                        pivot_next        = mid(nb_right[INDEX_BITS-1:0], right_bound);
                        probe_offset_next = '0;
                    end
                end
                OP_SKIP:
                begin
                    probe_offset_next = off_skip;
                    if (nb_skip > right_x || nb_skip < left_x)
                        status_next = ST_NOT_FOUND;
                end
                default:
                begin
                    // abort
                    status_next = ST_NOT_FOUND;
                end
            endcase
        end
    end

    assign chk_x = $signed({3'b000, pivot_next})
                 + $signed({probe_offset_next[OW-1], probe_offset_next});
    assign check_index = chk_x[OW-1:0];
    assign found_index = (status_next == ST_FOUND) ? chk_x[INDEX_BITS:0] : '1;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the binary search probe controller: directed and random searches.
module tb;

    import bsp_pkg::*;

    localparam int IDX_W    = 16;
    localparam int S_DATA_W = ((2*IDX_W+7)/8)*8;
    localparam int M_DATA_W = ((2*IDX_W+10)/8)*8;
    localparam int RANDOM_ITEMS = 1900;

    localparam logic [OP_W-1:0] OP_ABORT_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_ABORT_HI = 3'd7;

    typedef struct packed {
        logic [IDX_W+1:0] check_index;
        logic [IDX_W:0]   found_index;
        logic [ST_W-1:0]  status;
        logic             rejected;
    } probe_result_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // start_index, stop_index
    logic [OP_W-1:0]     s_tuser;   // opcode
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // check_index, found_index, zero pad
    logic [ST_W:0]       m_tuser;   // search_status, start_rejected

    // search state as the block should hold it
    logic [IDX_W-1:0]        srch_left;
    logic [IDX_W-1:0]        srch_right;
    logic [IDX_W-1:0]        srch_pivot;
    logic signed [IDX_W+1:0] srch_offset;
    logic [ST_W-1:0]         srch_status;

    probe_result_t expected_q[$];
    int errors;
    int cmd_count;
    int result_count;
    int found_count;
    int miss_count;
    int reject_count;
    int burst_left;

    int rdy_mode;
    int rdy_phase;

    binary_search_probe_controller #(.INDEX_BITS(IDX_W)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int zigzag(int off);
        if (off == 0)
            return 1;
        if (off > 0)
            return -off;
        return -off + 1;
    endfunction

    function automatic probe_result_t predict_command(logic [OP_W-1:0] op,
                                                      logic [IDX_W-1:0] a,
                                                      logic [IDX_W-1:0] b);
        probe_result_t r;
        int lo;
        int hi;
        int piv;
        int off;
        int nb;
        int chk;
        logic [ST_W-1:0] st;
        r   = '0;
        lo  = int'(srch_left);
        hi  = int'(srch_right);
        piv = int'(srch_pivot);
        off = int'(srch_offset);
        st  = srch_status;
        if (op == OP_START)
        begin
            if (a >= b)
            begin
                r.rejected = 1'b1;
                reject_count++;
            end
            else
            begin
                st  = ST_CONTINUE;
                lo  = int'(a);
                hi  = int'(b);
                piv = lo + (hi - lo) / 2;
                off = 0;
            end
        end
        else if (st == ST_CONTINUE)
        begin
            case (op)
                OP_EQUAL:
                    st = ST_FOUND;
                OP_LEFT:
                begin
                    nb = (off > 0) ? piv + zigzag(off) : piv + off - 1;
                    if (nb >= hi || nb < lo)
                        st = ST_NOT_FOUND;
                    else
                    begin
                        hi  = nb;
                        piv = lo + (hi - lo) / 2;
                        off = 0;
                    end
                end
                OP_RIGHT:
                begin
                    nb = (off < 0) ? piv + zigzag(off) : piv + off + 1;
                    if (nb <= lo || nb > hi)
                        st = ST_NOT_FOUND;
                    else
                    begin
                        lo  = nb;
                        piv = lo + (hi - lo) / 2;
                        off = 0;
                    end
                end
                OP_SKIP:
                begin
                    off = zigzag(off);
                    nb  = piv + off;
                    if (nb > hi || nb < lo)
                        st = ST_NOT_FOUND;
                end
                default:
                    st = ST_NOT_FOUND;
            endcase
            if (st == ST_FOUND)
                found_count++;
            else if (st == ST_NOT_FOUND)
                miss_count++;
        end
        srch_left   = lo[IDX_W-1:0];
        srch_right  = hi[IDX_W-1:0];
        srch_pivot  = piv[IDX_W-1:0];
        srch_offset = off[IDX_W+1:0];
        srch_status = st;
        chk = piv + off;
        r.check_index = chk[IDX_W+1:0];
        r.found_index = (st == ST_FOUND) ? chk[IDX_W:0] : '1;
        r.status      = st;
        return r;
    endfunction

    // one command; valid stays high on return so back-to-back transactions need no toggle
    task automatic send_command(logic [OP_W-1:0] op, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({b, a});
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        expected_q.push_back(predict_command(op, a, b));
        cmd_count++;
    endtask

    // receiver: phases of always-ready, coin-toss and mostly-stalled
    always @(posedge clk)
    begin
        if (rdy_phase == 0)
        begin
            rdy_mode  = $urandom_range(0, 2);
            rdy_phase = $urandom_range(20, 120);
        end
        rdy_phase--;
        case (rdy_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        probe_result_t exp_r;
        probe_result_t got_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_r.check_index = m_tdata[IDX_W+1:0];
            got_r.found_index = m_tdata[2*IDX_W+2:IDX_W+2];
            got_r.status      = m_tuser[ST_W-1:0];
            got_r.rejected    = m_tuser[ST_W];
            result_count++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result transaction, expected none actual %h",
                         $time, got_r);
                errors++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (got_r.check_index !== exp_r.check_index)
                begin
                    $display("%0t: check_index expected %h actual %h",
                             $time, exp_r.check_index, got_r.check_index);
                    errors++;
                end
                if (got_r.found_index !== exp_r.found_index)
                begin
                    $display("%0t: found_index expected %h actual %h",
                             $time, exp_r.found_index, got_r.found_index);
                    errors++;
                end
                if (got_r.status !== exp_r.status)
                begin
                    $display("%0t: search_status expected %0d actual %0d",
                             $time, exp_r.status, got_r.status);
                    errors++;
                end
                if (got_r.rejected !== exp_r.rejected)
                begin
                    $display("%0t: start_rejected expected %b actual %b",
                             $time, exp_r.rejected, got_r.rejected);
                    errors++;
                end
            end
        end
    end

    // outcomes before any start are ignored
    task automatic test_idle_after_reset();
        send_command(OP_EQUAL, 16'h0000, 16'h0000);
        send_command(OP_SKIP, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_start_rejects();
        send_command(OP_START, 16'hFFFF, 16'hFFFF);
        send_command(OP_START, 16'h0005, 16'h0005);
        send_command(OP_START, 16'hFFFF, 16'h0000);
    endtask

    task automatic test_search_walk();
        send_command(OP_START, 16'h0000, 16'hFFFF);
        send_command(OP_RIGHT, 16'h0000, 16'h0000);
        send_command(OP_LEFT, 16'h0000, 16'h0000);
        send_command(OP_SKIP, 16'h0000, 16'h0000);
        send_command(OP_SKIP, 16'h0000, 16'h0000);
        send_command(OP_EQUAL, 16'h0000, 16'h0000);
        send_command(OP_LEFT, 16'h0000, 16'h0000);
    endtask

    // skips that step off either end of the range
    task automatic test_skip_past_edges();
        send_command(OP_START, 16'h0000, 16'h0001);
        send_command(OP_SKIP, 16'h0000, 16'h0000);
        send_command(OP_SKIP, 16'h0000, 16'h0000);
        send_command(OP_START, 16'hFFFD, 16'hFFFF);
        send_command(OP_SKIP, 16'h0000, 16'h0000);
        send_command(OP_SKIP, 16'h0000, 16'h0000);
        send_command(OP_SKIP, 16'h0000, 16'h0000);
    endtask

    task automatic test_abort_codes();
        for (int op = OP_ABORT_LO; op <= OP_ABORT_HI; op++)
        begin
            send_command(OP_START, 16'h0100, 16'h0200);
            send_command(OP_W'(op), 16'h0000, 16'h0000);
        end
    endtask

    task automatic run_random_search();
        int lo;
        int hi;
        int tmp;
        int target;
        int skip_pct;
        int chk;
        int steps;
        int dice;
        logic [OP_W-1:0] op;
        case ($urandom_range(0, 4))
            0:
            begin
                lo = $urandom_range(0, 65535);
                hi = $urandom_range(0, 65535);
                if (lo > hi)
                begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
            end
            1:
            begin
                lo = $urandom_range(0, 65535 - 40);
                hi = lo + $urandom_range(1, 40);
            end
            2:
            begin
                hi = 65535 - $urandom_range(0, 3);
                lo = hi - $urandom_range(1, 60);
            end
            3:
            begin
                lo = $urandom_range(0, 3);
                hi = lo + $urandom_range(1, 60);
            end
            default:
            begin
                lo = $urandom_range(0, 1000);
                hi = $urandom_range(64000, 65535);
            end
        endcase
        case ($urandom_range(0, 9))
            0:       target = lo - 1;
            1:       target = hi + 1;
            default: target = $urandom_range(lo, hi);
        endcase
        skip_pct = ($urandom_range(0, 3) == 0) ? 40 : 10;
        send_command(OP_START, lo[IDX_W-1:0], hi[IDX_W-1:0]);
        steps = 0;
        while (srch_status == ST_CONTINUE && steps < 60)
        begin
            chk  = int'(srch_pivot) + int'(srch_offset);
            dice = $urandom_range(0, 99);
            if (dice < 2)
            begin
                // restart in mid-search
                send_command(OP_START, IDX_W'($urandom), IDX_W'($urandom));
                return;
            end
            if (dice < 4)
                op = OP_W'($urandom_range(OP_ABORT_LO, OP_ABORT_HI));
            else if (dice < 4 + skip_pct)
                op = OP_SKIP;
            else if (chk == target)
                op = OP_EQUAL;
            else if (target < chk)
                op = OP_LEFT;
            else
                op = OP_RIGHT;
            send_command(op, IDX_W'($urandom), IDX_W'($urandom));
            steps++;
        end
    endtask

    task automatic test_random_searches();
        int stop_at;
        stop_at = cmd_count + RANDOM_ITEMS;
        while (cmd_count < stop_at)
        begin
            if ($urandom_range(0, 99) < 12)
                send_command(OP_W'($urandom_range(0, 7)), IDX_W'($urandom), IDX_W'($urandom));
            else
                run_random_search();
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_START;
        m_tready     = 1'b0;
        srch_left    = '0;
        srch_right   = '0;
        srch_pivot   = '0;
        srch_offset  = '0;
        srch_status  = ST_NOT_FOUND;
        errors       = 0;
        cmd_count    = 0;
        result_count = 0;
        found_count  = 0;
        miss_count   = 0;
        reject_count = 0;
        burst_left   = 0;
        rdy_mode     = 0;
        rdy_phase    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_after_reset();
        test_start_rejects();
        test_search_walk();
        test_skip_past_edges();
        test_abort_codes();
        test_random_searches();

        s_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (10) @(posedge clk);

        $display("%0d commands sent, %0d result transactions checked", cmd_count, result_count);
        $display("searches found %0d, ended not found %0d, starts rejected %0d",
                 found_count, miss_count, reject_count);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("timeout with %0d results outstanding", expected_q.size());
        $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/bsp_pkg.sv
rtl/bsp_step.sv
rtl/binary_search_probe_controller.sv
tb/sv/tb.sv
